>>> hdl/bdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdr_pkg
// Shared types and constants of the button debounce and auto-repeat block.
// ----------------------------------------------------------------------------
package bdr_pkg;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int REPEAT_W    = 32;
  localparam int DEBOUNCE_W  = 16;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd1000;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_INVERT_INPUT   = 2'd0;
  localparam cfg_idx_t REG_REPORT_BOTH    = 2'd1;
  localparam cfg_idx_t REG_REPEAT_INTERVAL = 2'd2;
  localparam cfg_idx_t REG_DEBOUNCE       = 2'd3;

  // Configuration as seen by the evaluation logic
  typedef struct packed {
    logic                  invert_input;
    logic                  report_both;
    logic [REPEAT_W-1:0]   repeat_interval_us;
    logic [DEBOUNCE_W-1:0] debounce_us;
  } cfg_t;

  // Outcome of one poll
  typedef struct packed {
    logic emit;
    logic pressed;
    logic is_change;
  } evt_t;

endpackage : bdr_pkg
`default_nettype wire

>>> hdl/bdr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdr_in_if
// Poll channel: timestamp and raw pin level, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bdr_in_if #(
  parameter int TIME_BITS = 48
) ();
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] timestamp_us;
  logic                 raw_level;

  modport source (output valid, output timestamp_us, output raw_level, input ready);
  modport sink   (input valid, input timestamp_us, input raw_level, output ready);
endinterface : bdr_in_if
`default_nettype wire

>>> hdl/bdr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdr_out_if
// Report channel: button state, change flag and elapsed time.
// ----------------------------------------------------------------------------
interface bdr_out_if #(
  parameter int TIME_BITS = 48
) ();
  logic                 valid;
  logic                 ready;
  logic                 pressed;
  logic                 is_change;
  logic [TIME_BITS-1:0] elapsed_us;

  modport source (output valid, output pressed, output is_change, output elapsed_us,
                  input ready);
  modport sink   (input valid, input pressed, input is_change, input elapsed_us,
                  output ready);
endinterface : bdr_out_if
`default_nettype wire

>>> hdl/bdr_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdr_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bdr_cfg_if ();
  logic                           valid;
  logic                           ready;
  logic [bdr_pkg::CFG_IDX_W-1:0]  index;
  logic [bdr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : bdr_cfg_if
`default_nettype wire

>>> hdl/button_debounce_repeat_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_debounce_repeat_core
// Push-button debouncer with auto-repeat, one poll per cycle unless out_chan stalls.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  takes polls (timestamp_us, raw_level); a poll transfers when
//            valid and ready are both high.
//   out_chan delivers reports (pressed, is_change, elapsed_us); a poll makes
//            zero or one report.
//   cfg_chan writes registers 0..3 (invert, report presses, repeat interval,
//            debounce time); always ready, write only while idle.
// Timing: a poll is registered in the input register, is evaluated against
//   the stored state and, if it reports, lands in the output register,
//   from which the report can transfer. One poll per cycle is sustained
//   unless out_chan stalls; input and output registers form two stages.
// Stall: while out_chan holds a report and ready is low, the evaluation stage
//   holds; in_chan stays ready until the input register is also occupied.
// Reset (rst_n low, synchronous): both stages empty, state released, change and
//   report times zero, debounce time 1000 us, other registers zero.
// ----------------------------------------------------------------------------
module button_debounce_repeat_core #(
  parameter int TIME_BITS = 48
) (
  input  wire       clk,
  input  wire       rst_n,
  bdr_in_if.sink    in_chan,
  bdr_out_if.source out_chan,
  bdr_cfg_if.sink   cfg_chan
);
  import bdr_pkg::*;

  cfg_t                 cfg_r, cfg_nxt;

  logic                 s1_valid_r, s1_valid_nxt;
  logic [TIME_BITS-1:0] s1_ts_r;
  logic                 s1_raw_r;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_pressed_r;
  logic                 out_change_r;
  logic [TIME_BITS-1:0] out_elapsed_r;

  logic                 adv;
  logic                 fire;
  logic                 load_in;
  evt_t                 evt;
  logic [TIME_BITS-1:0] elapsed;

  // Configuration registers
  assign cfg_chan.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_INVERT_INPUT:    cfg_nxt.invert_input       = cfg_chan.data[0];
        REG_REPORT_BOTH:     cfg_nxt.report_both        = cfg_chan.data[0];
        REG_REPEAT_INTERVAL: cfg_nxt.repeat_interval_us = cfg_chan.data[REPEAT_W-1:0];
        REG_DEBOUNCE:        cfg_nxt.debounce_us        = cfg_chan.data[DEBOUNCE_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.invert_input       <= 1'b0;
      cfg_r.report_both        <= 1'b0;
      cfg_r.repeat_interval_us <= '0;
      cfg_r.debounce_us        <= DEBOUNCE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Handshake: the evaluation stage advances when the output register is free or drains
  assign adv           = !out_valid_r || out_chan.ready;
  assign fire          = s1_valid_r && adv;
  assign in_chan.ready = !s1_valid_r || adv;
  assign load_in       = in_chan.valid && in_chan.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load_in) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = evt.emit;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      s1_ts_r  <= in_chan.timestamp_us;
      s1_raw_r <= in_chan.raw_level;
    end
    // Load only polls that report
    if (fire && evt.emit) begin
      out_pressed_r <= evt.pressed;
      out_change_r  <= evt.is_change;
      out_elapsed_r <= elapsed;
    end
  end

  bdr_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .cfg          (cfg_r),
    .timestamp_us (s1_ts_r),
    .raw_level    (s1_raw_r),
    .evt          (evt),
    .elapsed_us   (elapsed)
  );

  assign out_chan.valid      = out_valid_r;
  assign out_chan.pressed    = out_pressed_r;
  assign out_chan.is_change  = out_change_r;
  assign out_chan.elapsed_us = out_elapsed_r;

`ifndef SYNTH
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("stages not empty after reset");

  a_release_is_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_change_r || out_pressed_r))
    else $error("repeat report while released");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(s1_ts_r) && $stable(s1_raw_r)))
    else $error("poll lost while output stalled");

  a_no_emit_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && evt.emit) |=> out_valid_r)
    else $error("report not loaded");
`endif

endmodule : button_debounce_repeat_core
`default_nettype wire

>>> hdl/bdr_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdr_step
// Debounce and repeat decision for one poll, plus the debounced state and
// the change and report timestamps it updates.
// ----------------------------------------------------------------------------
module bdr_step #(
  parameter int TIME_BITS = 48
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  fire,
  input  bdr_pkg::cfg_t        cfg,
  input  wire [TIME_BITS-1:0]  timestamp_us,
  input  wire                  raw_level,
  output bdr_pkg::evt_t        evt,
  output logic [TIME_BITS-1:0] elapsed_us
);
  import bdr_pkg::*;

  logic                 state_r, state_nxt;
  logic [TIME_BITS-1:0] last_change_r, last_change_nxt;
  logic [TIME_BITS-1:0] last_report_r, last_report_nxt;

  logic                 level;
  logic [TIME_BITS-1:0] since_change;
  logic [TIME_BITS-1:0] since_report;
  logic [TIME_BITS-1:0] debounce_ext;
  logic [TIME_BITS-1:0] repeat_ext;
  logic                 accept_chg;
  logic                 repeat_hit;

  assign level        = raw_level ^ cfg.invert_input;
  assign since_change = timestamp_us - last_change_r;
  assign since_report = timestamp_us - last_report_r;
  assign debounce_ext = {{(TIME_BITS-DEBOUNCE_W){1'b0}}, cfg.debounce_us};
  assign repeat_ext   = {{(TIME_BITS-REPEAT_W){1'b0}}, cfg.repeat_interval_us};

  assign accept_chg = (level != state_r) && (since_change > debounce_ext);
  // Repeats follow the live level, not the debounced state
  assign repeat_hit = level && (|cfg.repeat_interval_us) && (since_report >= repeat_ext);

  always_comb begin
    evt.is_change = accept_chg;
    evt.pressed   = accept_chg ? level : 1'b1;
    evt.emit      = accept_chg ? (!level || cfg.report_both) : repeat_hit;
    elapsed_us    = since_change;
  end

  always_comb begin
    state_nxt       = state_r;
    last_change_nxt = last_change_r;
    last_report_nxt = last_report_r;
    if (fire) begin
      if (accept_chg) begin
        state_nxt       = level;
        last_change_nxt = timestamp_us;
        if (level) begin
          last_report_nxt = timestamp_us;
        end
      end else if (repeat_hit) begin
        last_report_nxt = timestamp_us;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= 1'b0;
      last_change_r <= '0;
      last_report_r <= '0;
    end else begin
      state_r       <= state_nxt;
      last_change_r <= last_change_nxt;
      last_report_r <= last_report_nxt;
    end
  end

endmodule : bdr_step
`default_nettype wire
